/* rtl/segi_pkg.sv */
// ----------------------------------------------------------------------------
// segi_pkg
// Widths and word types shared by the segment intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package segi_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int COORD_FRAC  = 8;
   localparam int T_FRAC      = 24;

   // edge vectors and offsets
   localparam int DIFF_W  = COORD_WIDTH + 1;
   // one cross-product term
   localparam int PROD_W  = 2 * DIFF_W;
   // denominator and numerators
   localparam int CROSS_W = PROD_W + 1;
   // divider remainder, one bit above the magnitude for the left shift
   localparam int REM_W   = CROSS_W + 1;
   // quotient: integer bit plus fraction bits
   localparam int Q_W     = T_FRAC + 1;
   // number of divider stages, one quotient bit each
   localparam int DIV_STAGES = Q_W;
   // t times edge vector
   localparam int PX_W    = Q_W + 1 + DIFF_W;
   localparam int SHR_W   = PX_W - T_FRAC;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] a_start_x;
      logic signed [COORD_WIDTH-1:0] a_start_y;
      logic signed [COORD_WIDTH-1:0] a_end_x;
      logic signed [COORD_WIDTH-1:0] a_end_y;
      logic signed [COORD_WIDTH-1:0] b_start_x;
      logic signed [COORD_WIDTH-1:0] b_start_y;
      logic signed [COORD_WIDTH-1:0] b_end_x;
      logic signed [COORD_WIDTH-1:0] b_end_y;
   } req_type;

   typedef struct packed {
      logic                          hit;
      logic signed [COORD_WIDTH-1:0] cross_x;
      logic signed [COORD_WIDTH-1:0] cross_y;
   } rsp_type;

   // what rides along the divider untouched
   typedef struct packed {
      logic                          hit;
      logic signed [DIFF_W-1:0]      dax;
      logic signed [DIFF_W-1:0]      day;
      logic signed [COORD_WIDTH-1:0] ax0;
      logic signed [COORD_WIDTH-1:0] ay0;
   } side_type;

   typedef struct packed {
      logic [REM_W-1:0]   rem;
      logic [CROSS_W-1:0] den;
      logic [Q_W-1:0]     q;
      side_type           side;
   } div_type;

endpackage

`default_nettype wire

/* rtl/segi_if.sv */
// ----------------------------------------------------------------------------
// segi_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface segi_req_if;
   logic              valid;
   logic              ready;
   segi_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface segi_rsp_if;
   logic              valid;
   logic              ready;
   segi_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/segi_front.sv */
// ----------------------------------------------------------------------------
// segi_front
// Differences, cross products, cross sums and the hit tests, four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module segi_front (
   input  wire logic            clock,
   input  wire logic            reset,
   segi_req_if.sink             req,
   output logic                 o_valid,
   input  wire logic            o_ready,
   output segi_pkg::div_type    o_data
);
   import segi_pkg::*;

   logic en1, en2, en3, en4;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   // stage 1
   logic signed [DIFF_W-1:0]      dax_ff, day_ff, dbx_ff, dby_ff, ox_ff, oy_ff;
   logic signed [COORD_WIDTH-1:0] ax0_ff, ay0_ff;
   // stage 2
   logic signed [PROD_W-1:0]      p_dd1_ff, p_dd2_ff, p_s1_ff, p_s2_ff, p_t1_ff, p_t2_ff;
   side_type                      side2_ff;
   // stage 3
   logic signed [CROSS_W-1:0]     den_ff, sn_ff, tn_ff;
   side_type                      side3_ff;
   // stage 4
   div_type                       out_ff, out_in;

   logic dpos;

   assign en4 = !v4_ff || o_ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         dax_ff <= DIFF_W'(req.data.a_end_x) - DIFF_W'(req.data.a_start_x);
         day_ff <= DIFF_W'(req.data.a_end_y) - DIFF_W'(req.data.a_start_y);
         dbx_ff <= DIFF_W'(req.data.b_end_x) - DIFF_W'(req.data.b_start_x);
         dby_ff <= DIFF_W'(req.data.b_end_y) - DIFF_W'(req.data.b_start_y);
         ox_ff  <= DIFF_W'(req.data.a_start_x) - DIFF_W'(req.data.b_start_x);
         oy_ff  <= DIFF_W'(req.data.a_start_y) - DIFF_W'(req.data.b_start_y);
         ax0_ff <= req.data.a_start_x;
         ay0_ff <= req.data.a_start_y;
      end
      if (en2) begin
         p_dd1_ff <= dax_ff * dby_ff;
         p_dd2_ff <= dbx_ff * day_ff;
         p_s1_ff  <= dax_ff * oy_ff;
         p_s2_ff  <= day_ff * ox_ff;
         p_t1_ff  <= dbx_ff * oy_ff;
         p_t2_ff  <= dby_ff * ox_ff;
         side2_ff.hit <= 1'b0;
         side2_ff.dax <= dax_ff;
         side2_ff.day <= day_ff;
         side2_ff.ax0 <= ax0_ff;
         side2_ff.ay0 <= ay0_ff;
      end
      if (en3) begin
         den_ff   <= CROSS_W'(p_dd1_ff) - CROSS_W'(p_dd2_ff);
         sn_ff    <= CROSS_W'(p_s1_ff) - CROSS_W'(p_s2_ff);
         tn_ff    <= CROSS_W'(p_t1_ff) - CROSS_W'(p_t2_ff);
         side3_ff <= side2_ff;
      end
      if (en4) out_ff <= out_in;
   end

   // parallel lines, then sign and bound tests; fold to magnitudes for the divider
   always_comb begin
      dpos = !den_ff[CROSS_W-1];
      out_in          = '0;
      out_in.side     = side3_ff;
      out_in.side.hit = (den_ff != '0)
                     && ((sn_ff < 0) != dpos) && ((tn_ff < 0) != dpos)
                     && ((sn_ff > den_ff) != dpos) && ((tn_ff > den_ff) != dpos);
      out_in.rem = {1'b0, (dpos ? tn_ff : -tn_ff)};
      out_in.den = dpos ? den_ff : -den_ff;
      out_in.q   = '0;
   end

   assign o_valid = v4_ff;
   assign o_data  = out_ff;

endmodule

`default_nettype wire

/* rtl/segi_divider.sv */
// ----------------------------------------------------------------------------
// segi_divider
// Restoring fraction divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module segi_divider (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            i_valid,
   output logic                 i_ready,
   input  wire segi_pkg::div_type i_data,
   output logic                 o_valid,
   input  wire logic            o_ready,
   output segi_pkg::div_type    o_data
);
   import segi_pkg::*;

   div_type              st_ff [DIV_STAGES];
   div_type              st_in [DIV_STAGES];
   logic [DIV_STAGES-1:0] v_ff;
   logic [DIV_STAGES:0]   en;

   assign en[DIV_STAGES] = o_ready;

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      div_type          src;
      logic [REM_W-1:0] trial;
      logic             ge;
      logic             src_v;

      if (k == 0) begin : g_first
         assign src   = i_data;
         assign src_v = i_valid;
         // integer bit: no shift
         assign trial = i_data.rem;
      end else begin : g_rest
         assign src   = st_ff[k-1];
         assign src_v = v_ff[k-1];
         assign trial = {st_ff[k-1].rem[REM_W-2:0], 1'b0};
      end

      assign en[k] = !v_ff[k] || en[k+1];
      assign ge    = trial >= {1'b0, src.den};

      always_comb begin
         st_in[k]      = src;
         st_in[k].rem  = ge ? (trial - {1'b0, src.den}) : trial;
         st_in[k].q    = {src.q[Q_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en[k]) begin
            v_ff[k] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) st_ff[k] <= st_in[k];
      end
   end

   assign i_ready = en[0];
   assign o_valid = v_ff[DIV_STAGES-1];
   assign o_data  = st_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

/* rtl/segi_back.sv */
// ----------------------------------------------------------------------------
// segi_back
// Scale the edge vector by t, floor, add the start point, register the word.
// ----------------------------------------------------------------------------
`default_nettype none

module segi_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            i_valid,
   output logic                 i_ready,
   input  wire segi_pkg::div_type i_data,
   segi_rsp_if.source           rsp
);
   import segi_pkg::*;

   logic en1, en2;
   logic v1_ff, v2_ff;
   logic signed [PX_W-1:0]        px_ff, py_ff;
   logic signed [COORD_WIDTH-1:0] ax0_ff, ay0_ff;
   logic                          hit_ff;
   rsp_type                       out_ff, out_in;
   logic signed [SHR_W-1:0]       sx, sy;
   logic signed [Q_W:0]           t_s;

   assign en2 = !v2_ff || rsp.ready;
   assign en1 = !v1_ff || en2;
   assign i_ready = en1;
   assign t_s = {1'b0, i_data.q};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= i_valid;
         if (en2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         px_ff  <= t_s * i_data.side.dax;
         py_ff  <= t_s * i_data.side.day;
         ax0_ff <= i_data.side.ax0;
         ay0_ff <= i_data.side.ay0;
         hit_ff <= i_data.side.hit;
      end
      if (en2) out_ff <= out_in;
   end

   always_comb begin
      sx = px_ff[PX_W-1:T_FRAC];
      sy = py_ff[PX_W-1:T_FRAC];
      out_in.hit     = hit_ff;
      out_in.cross_x = hit_ff ? COORD_WIDTH'(sx + SHR_W'(ax0_ff)) : '0;
      out_in.cross_y = hit_ff ? COORD_WIDTH'(sy + SHR_W'(ay0_ff)) : '0;
   end

   assign rsp.valid = v2_ff;
   assign rsp.data  = out_ff;

endmodule

`default_nettype wire

/* rtl/segment_intersection.sv */
// ----------------------------------------------------------------------------
// segment_intersection
// Fixed-point intersection of two line segments, fully pipelined.
// ----------------------------------------------------------------------------
// Each request word carries two segments in signed fixed point (8 fraction
// bits); the response word gives hit and the crossing point, zero on a miss.
// One word is taken every cycle unless a stalled response has filled the
// pipe. The pipe has 4 front stages (differences, products, cross sums,
// tests), one divider stage per quotient bit (T_FRAC + 1 = 25) and 2 back
// stages. Each stage holds its own valid bit, so a stalled response only
// backs up the full stages and words keep entering until the pipe is packed.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection (
   input  wire logic clock,
   input  wire logic reset,
   segi_req_if.sink   req,
   segi_rsp_if.source rsp
);
   import segi_pkg::*;

   // front to divider
   logic    f_valid, f_ready;
   div_type f_data;
   // divider to back end
   logic    d_valid, d_ready;
   div_type d_data;

   // differences, products and the hit decision
   segi_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .o_valid (f_valid),
      .o_ready (f_ready),
      .o_data  (f_data)
   );

   // t = |t_numer| / |denom| to T_FRAC fraction bits, truncated
   segi_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .i_valid (f_valid),
      .i_ready (f_ready),
      .i_data  (f_data),
      .o_valid (d_valid),
      .o_ready (d_ready),
      .o_data  (d_data)
   );

   // start point plus floored t times edge vector
   segi_back u_back (
      .clock   (clock),
      .reset   (reset),
      .i_valid (d_valid),
      .i_ready (d_ready),
      .i_data  (d_data),
      .rsp     (rsp)
   );

   // a miss always reports the origin
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.data.hit |-> rsp.data.cross_x == '0 && rsp.data.cross_y == '0)
      else $error("miss with nonzero point");

   // a ready sink opens the whole pipe back to the request side
   a_ready_through: assert property (@(posedge clock) disable iff (reset)
      rsp.ready |-> req.ready)
      else $error("request stalled while response side is ready");

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("response valid right after reset");

endmodule

`default_nettype wire
